// ===== rtl/dns_txt_answer_extractor_macros.svh =====
`ifndef DNS_TXT_ANSWER_EXTRACTOR_MACROS_SVH
`define DNS_TXT_ANSWER_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define DTX_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtx assertion failed");

// next-cycle implication
`define DTX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtx assertion failed");

`endif

// ===== rtl/dtx_pkg.sv =====
package dtx_pkg;

   localparam logic [15:0] DTX_WANTED_TYPE_RESET = 16'd16;
   localparam int          DTX_QUEUE_DEPTH       = 4;

   localparam logic [3:0] HEADER_BYTES = 4'd12;
   localparam logic [3:0] QFIXED_BYTES = 4'd4;
   localparam logic [3:0] AFIXED_BYTES = 4'd10;

   typedef enum logic [3:0] {
      PH_HDR     = 4'd0,
      PH_QNAME   = 4'd1,
      PH_QLABEL  = 4'd2,
      PH_QPTR    = 4'd3,
      PH_QFIXED  = 4'd4,
      PH_ANAME   = 4'd5,
      PH_ALABEL  = 4'd6,
      PH_APTR    = 4'd7,
      PH_AFIXED  = 4'd8,
      PH_SKIP    = 4'd9,
      PH_STRLEN  = 4'd10,
      PH_STRDATA = 4'd11,
      PH_DONE    = 4'd12,
      PH_ERROR   = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TEXT = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_NO_MATCH  = 2'd2
   } status_type;

   // results caused by one item, emitted in order text, end, done
   typedef struct packed {
      logic       has_text;
      logic       has_end;
      logic       has_done;
      logic [7:0] text;
      logic [15:0] rec;
      status_type status;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/dns_txt_answer_extractor.sv =====
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   msg_byte, msg_last
// rsp      out        rsp_valid/rsp_stall   result_kind, text_byte, record_number,
//                                           done_status, run_last
// csr      in         csr_valid/csr_ready   wanted_type
//
// While req_stall is low one byte is taken per cycle; the parser updates counters then.
// Each byte yields zero to three results, queued as one entry and sent one per cycle,
// when rsp_stall is low; output bandwidth (one result a cycle) sets the sustained text rate.
// req_stall rises only when the result queue (QUEUE_DEPTH entries) is full.
// Synchronous reset clears parser state, queue and output; wanted_type resets to 16.
module dns_txt_answer_extractor #(
   parameter int QUEUE_DEPTH = dtx_pkg::DTX_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_msg_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [15:0] rsp_record_number,
   output logic [1:0]  rsp_done_status,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wanted_type
);
   import dtx_pkg::*;

   logic [15:0]  wanted_type_ff, wanted_type_in;
   logic         push;
   logic         pop;
   bundle_type   push_data;
   bundle_type   head;
   q_status_type q_status;

   assign csr_ready      = 1'b1;
   assign wanted_type_in = (csr_valid && csr_ready) ? csr_wanted_type : wanted_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff <= DTX_WANTED_TYPE_RESET;
      end else begin
         wanted_type_ff <= wanted_type_in;
      end
   end

   dtx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_msg_byte (req_msg_byte),
      .req_msg_last (req_msg_last),
      .wanted_type  (wanted_type_ff),
      .q_status     (q_status),
      .push         (push),
      .push_data    (push_data)
   );

   dtx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   dtx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_text_byte     (rsp_text_byte),
      .rsp_record_number (rsp_record_number),
      .rsp_done_status   (rsp_done_status),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

// ===== rtl/dtx_queue.sv =====
module dtx_queue #(
   parameter int DEPTH = dtx_pkg::DTX_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dtx_pkg::bundle_type   push_data,
   input  logic                  pop,
   output dtx_pkg::bundle_type   head,
   output dtx_pkg::q_status_type status
);
   import dtx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/dtx_front.sv =====
module dtx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_msg_byte,
   input  logic                  req_msg_last,
   input  logic [15:0]           wanted_type,
   input  dtx_pkg::q_status_type q_status,
   output logic                  push,
   output dtx_pkg::bundle_type   push_data
);
   import dtx_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [15:0] questions_ff, questions_in;
   logic [15:0] answers_ff, answers_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rdata_ff, rdata_in;
   logic [7:0]  string_ff, string_in;
   logic [5:0]  label_ff, label_in;
   logic [15:0] matched_ff, matched_in;
   logic        error_ff, error_in;
   logic        accept;
   bundle_type  bundle;
   logic        in_q;
   logic [7:0]  b;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_msg_byte;
   assign in_q      = (phase_ff == PH_QNAME) || (phase_ff == PH_QLABEL) ||
                      (phase_ff == PH_QPTR);

   always_comb begin
      phase_in     = phase_ff;
      fbc_in       = fbc_ff;
      questions_in = questions_ff;
      answers_in   = answers_ff;
      rtype_in     = rtype_ff;
      rdata_in     = rdata_ff;
      string_in    = string_ff;
      label_in     = label_ff;
      matched_in   = matched_ff;
      error_in     = error_ff;
      bundle       = '0;
      bundle.rec   = matched_ff;
      bundle.text  = b;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR: begin
               if (fbc_ff == 4'd4) questions_in = {b, questions_ff[7:0]};
               if (fbc_ff == 4'd5) questions_in = {questions_ff[15:8], b};
               if (fbc_ff == 4'd6) answers_in = {b, answers_ff[7:0]};
               if (fbc_ff == 4'd7) answers_in = {answers_ff[15:8], b};
               fbc_in = fbc_ff + 4'd1;
               if (fbc_in >= HEADER_BYTES) begin
                  fbc_in = '0;
                  if (questions_in != '0) phase_in = PH_QNAME;
                  else if (answers_in != '0) phase_in = PH_ANAME;
                  else phase_in = PH_DONE;
               end
            end
            PH_QNAME, PH_ANAME: begin
               if (b == 8'd0) begin
                  fbc_in   = '0;
                  phase_in = in_q ? PH_QFIXED : PH_AFIXED;
               end else if (b[7:6] == 2'b11) begin
                  phase_in = in_q ? PH_QPTR : PH_APTR;
               end else if (b[7:6] != 2'b00) begin
                  error_in = 1'b1;
                  phase_in = PH_ERROR;
               end else begin
                  label_in = b[5:0];
                  phase_in = in_q ? PH_QLABEL : PH_ALABEL;
               end
            end
            PH_QLABEL, PH_ALABEL: begin
               label_in = label_ff - 6'd1;
               if (label_in == '0) phase_in = in_q ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR, PH_APTR: begin
               fbc_in   = '0;
               phase_in = in_q ? PH_QFIXED : PH_AFIXED;
            end
            PH_QFIXED: begin
               fbc_in = fbc_ff + 4'd1;
               if (fbc_in >= QFIXED_BYTES) begin
                  fbc_in       = '0;
                  questions_in = questions_ff - 16'd1;
                  if (questions_in != '0) phase_in = PH_QNAME;
                  else if (answers_in != '0) phase_in = PH_ANAME;
                  else phase_in = PH_DONE;
               end
            end
            PH_AFIXED: begin
               if (fbc_ff == 4'd0) rtype_in = {b, rtype_ff[7:0]};
               if (fbc_ff == 4'd1) rtype_in = {rtype_ff[15:8], b};
               if (fbc_ff == 4'd8) rdata_in = {b, rdata_ff[7:0]};
               if (fbc_ff == 4'd9) rdata_in = {rdata_ff[15:8], b};
               fbc_in = fbc_ff + 4'd1;
               if (fbc_in >= AFIXED_BYTES) begin
                  fbc_in = '0;
                  if (rtype_in != wanted_type) begin
                     if (rdata_in == '0) begin
                        answers_in = answers_ff - 16'd1;
                        phase_in   = (answers_in != '0) ? PH_ANAME : PH_DONE;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else if (rdata_in == '0) begin
                     bundle.has_end = 1'b1;
                     matched_in     = matched_ff + 16'd1;
                     answers_in     = answers_ff - 16'd1;
                     phase_in       = (answers_in != '0) ? PH_ANAME : PH_DONE;
                  end else begin
                     phase_in = PH_STRLEN;
                  end
               end
            end
            PH_SKIP: begin
               rdata_in = rdata_ff - 16'd1;
               if (rdata_in == '0) begin
                  answers_in = answers_ff - 16'd1;
                  phase_in   = (answers_in != '0) ? PH_ANAME : PH_DONE;
               end
            end
            PH_STRLEN: begin
               rdata_in = rdata_ff - 16'd1;
               if ({8'd0, b} > rdata_in) begin
                  error_in = 1'b1;
                  phase_in = PH_ERROR;
               end else if (b == 8'd0) begin
                  if (rdata_in == '0) begin
                     bundle.has_end = 1'b1;
                     matched_in     = matched_ff + 16'd1;
                     answers_in     = answers_ff - 16'd1;
                     phase_in       = (answers_in != '0) ? PH_ANAME : PH_DONE;
                  end
               end else begin
                  string_in = b;
                  phase_in  = PH_STRDATA;
               end
            end
            PH_STRDATA: begin
               bundle.has_text = 1'b1;
               string_in       = string_ff - 8'd1;
               rdata_in        = rdata_ff - 16'd1;
               if (string_in == '0) begin
                  if (rdata_in == '0) begin
                     bundle.has_end = 1'b1;
                     matched_in     = matched_ff + 16'd1;
                     answers_in     = answers_ff - 16'd1;
                     phase_in       = (answers_in != '0) ? PH_ANAME : PH_DONE;
                  end else begin
                     phase_in = PH_STRLEN;
                  end
               end
            end
            default: begin
            end
         endcase

         if (req_msg_last) begin
            bundle.has_done = 1'b1;
            if (error_in || phase_in != PH_DONE) bundle.status = ST_MALFORMED;
            else if (matched_in == '0) bundle.status = ST_NO_MATCH;
            else bundle.status = ST_OK;
            phase_in     = PH_HDR;
            fbc_in       = '0;
            questions_in = '0;
            answers_in   = '0;
            rtype_in     = '0;
            rdata_in     = '0;
            string_in    = '0;
            label_in     = '0;
            matched_in   = '0;
            error_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         fbc_ff       <= '0;
         questions_ff <= '0;
         answers_ff   <= '0;
         rtype_ff     <= '0;
         rdata_ff     <= '0;
         string_ff    <= '0;
         label_ff     <= '0;
         matched_ff   <= '0;
         error_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fbc_ff       <= fbc_in;
         questions_ff <= questions_in;
         answers_ff   <= answers_in;
         rtype_ff     <= rtype_in;
         rdata_ff     <= rdata_in;
         string_ff    <= string_in;
         label_ff     <= label_in;
         matched_ff   <= matched_in;
         error_ff     <= error_in;
      end
   end

   assign push      = accept && (bundle.has_text || bundle.has_end || bundle.has_done);
   assign push_data = bundle;

endmodule

// ===== rtl/dtx_back.sv =====
module dtx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dtx_pkg::bundle_type   head,
   input  dtx_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [7:0]            rsp_text_byte,
   output logic [15:0]           rsp_record_number,
   output logic [1:0]            rsp_done_status,
   output logic                  rsp_run_last
);
   import dtx_pkg::*;

   logic        valid_ff, valid_in;
   logic [2:0]  taken_ff, taken_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  text_ff, text_in;
   logic [15:0] rec_ff, rec_in;
   status_type  status_ff, status_in;
   logic        last_ff, last_in;
   logic [2:0]  pend;
   logic [2:0]  sel;
   logic        load;

   assign pend = {head.has_done, head.has_end, head.has_text} & ~taken_ff;
   assign load = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in  = valid_ff;
      taken_in  = taken_ff;
      kind_in   = kind_ff;
      text_in   = text_ff;
      rec_in    = rec_ff;
      status_in = status_ff;
      last_in   = last_ff;
      sel       = 3'b100;
      pop       = 1'b0;
      priority if (pend[0]) sel = 3'b001;
      else if (pend[1]) sel = 3'b010;
      else sel = 3'b100;
      if (load) begin
         valid_in  = 1'b1;
         last_in   = ((pend & ~sel) == 3'b000);
         text_in   = sel[0] ? head.text : 8'd0;
         rec_in    = sel[2] ? 16'd0 : head.rec;
         status_in = sel[2] ? head.status : ST_OK;
         if (sel[0]) kind_in = KIND_TEXT;
         else if (sel[1]) kind_in = KIND_END;
         else kind_in = KIND_DONE;
         if (last_in) begin
            pop      = 1'b1;
            taken_in = '0;
         end else begin
            taken_in = taken_ff | sel;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         taken_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      text_ff   <= text_in;
      rec_ff    <= rec_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_text_byte     = text_ff;
   assign rsp_record_number = rec_ff;
   assign rsp_done_status   = status_ff;
   assign rsp_run_last      = last_ff;

endmodule

// ===== rtl/dtx_checker.sv =====
`include "dns_txt_answer_extractor_macros.svh"

module dtx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_text_byte,
   input logic [15:0] rsp_record_number,
   input logic [1:0]  rsp_done_status,
   input logic        rsp_run_last
);
   import dtx_pkg::*;

   `DTX_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_text_byte) && $stable(rsp_record_number))
   `DTX_ASSERT_IMPL(a_done_last, rsp_valid && rsp_result_kind == KIND_DONE, rsp_run_last)
   `DTX_ASSERT_IMPL(a_done_clean, rsp_valid && rsp_result_kind == KIND_DONE, rsp_record_number == 16'd0 && rsp_text_byte == 8'd0)
   `DTX_ASSERT_IMPL(a_status_zero, rsp_valid && rsp_result_kind != KIND_DONE, rsp_done_status == ST_OK)

endmodule

bind dns_txt_answer_extractor dtx_checker u_checker (.*);
